@@ rtl/wwpm_pkg.sv @@
// Shared types and constants for the weighted window position mean block.
`timescale 1ns / 1ps

package wwpm_pkg;

	localparam int COORD_W  = 32;   // signed Q16.16 coordinate
	localparam int WEIGHT_W = 16;   // unsigned Q0.16 weight
	localparam int PROD_W   = COORD_W + WEIGHT_W + 1;
	localparam int HELD_W   = 4;
	localparam int STEP_W   = 3;

	// Command codes carried by the command field.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	// Four operand loads plus one trailing accumulate.
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z,
		AXIS_W
	} axis_t;

	typedef struct packed {
		logic  clear;
		logic  load;
		logic  accum;
		logic  subtract;
		axis_t axis;
	} acc_ctrl_t;

endpackage

@@ rtl/wwpm_div.sv @@
// Serial restoring divider: signed running sum divided by the unsigned weight sum.
`timescale 1ns / 1ps

module wwpm_div
	import wwpm_pkg::*;
#(
	parameter int DVD_W = 53,
	parameter int DVS_W = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DVD_W-1:0]   dividend,
	input  logic        [DVS_W-1:0]   divisor,
	output logic                      done,
	output logic signed [COORD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             take;
	logic [DVD_W-1:0] magnitude;
	logic [DVD_W-1:0] signed_quo;

	assign shifted   = {rem_q, quo_q[DVD_W-1]};
	assign diff      = shifted - {1'b0, dvs_q};
	assign take      = (shifted >= {1'b0, dvs_q});
	assign magnitude = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;

	// The quotient register holds the magnitude; the sign is put back on the way out.
	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed'(signed_quo[COORD_W-1:0]);
	assign done       = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			dvs_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
				neg_q  <= dividend[DVD_W-1];
				dvs_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= magnitude;
			end else if (busy_q) begin
				rem_q <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/wwpm_acc.sv @@
// Shared multiplier and accumulator that keeps the running weighted sums and weight sum.
`timescale 1ns / 1ps

module wwpm_acc
	import wwpm_pkg::*;
#(
	parameter int SUM_W = 53,
	parameter int TW_W  = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  acc_ctrl_t                 ctrl,
	input  logic signed [COORD_W-1:0] operand,
	input  logic        [WEIGHT_W-1:0] factor,
	output logic signed [SUM_W-1:0]   sum_x,
	output logic signed [SUM_W-1:0]   sum_y,
	output logic signed [SUM_W-1:0]   sum_z,
	output logic        [TW_W-1:0]    total
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  sum_x_q;
	logic signed [SUM_W-1:0]  sum_y_q;
	logic signed [SUM_W-1:0]  sum_z_q;
	logic        [TW_W-1:0]   total_q;

	logic signed [SUM_W-1:0]  delta;
	logic        [TW_W-1:0]   delta_w;

	assign delta   = {{(SUM_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign delta_w = TW_W'(prod_s1[WEIGHT_W-1:0]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= operand * signed'({1'b0, factor});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			total_q <= '0;
		end else if (ctrl.clear) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			total_q <= '0;
		end else if (ctrl.accum) begin
			unique case (ctrl.axis)
				AXIS_X: sum_x_q <= ctrl.subtract ? sum_x_q - delta : sum_x_q + delta;
				AXIS_Y: sum_y_q <= ctrl.subtract ? sum_y_q - delta : sum_y_q + delta;
				AXIS_Z: sum_z_q <= ctrl.subtract ? sum_z_q - delta : sum_z_q + delta;
				AXIS_W: total_q <= ctrl.subtract ? total_q - delta_w : total_q + delta_w;
				default: ;
			endcase
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_z = sum_z_q;
	assign total = total_q;

endmodule

@@ rtl/weighted_window_position_mean_top.sv @@
// Top level: sample window, sequencer, shared accumulator and divider.
//
//  Channel  Handshake             Payload
//  -------  --------------------  -----------------------------------------------
//  input    in_valid / in_ready   command, sample_x, sample_y, sample_z, weight
//  output   out_valid / out_ready mean_x, mean_y, mean_z, held_count, zero_weight
//
// A start transaction runs no division. An add transaction on a full window runs
// an eviction pass, an add pass and then the serial divider once per axis; while
// the window is still filling there is no eviction pass. A zero weight sum skips
// the divisions. in_ready is high only while the sequencer is idle. A finished
// result waits in the output register while the next transaction is accepted
// and worked on.
// Reset empties the window and clears the sums; no clearing pass is needed.
`timescale 1ns / 1ps

module weighted_window_position_mean_top
	import wwpm_pkg::*;
#(
	parameter int WINDOW = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic signed [COORD_W-1:0]  sample_x,
	input  logic signed [COORD_W-1:0]  sample_y,
	input  logic signed [COORD_W-1:0]  sample_z,
	input  logic        [WEIGHT_W-1:0] weight,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  mean_x,
	output logic signed [COORD_W-1:0]  mean_y,
	output logic signed [COORD_W-1:0]  mean_z,
	output logic        [HELD_W-1:0]   held_count,
	output logic                       zero_weight
);

	localparam int FILL_W     = $clog2(WINDOW + 1);
	localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SLOT_SUM_W = $clog2(2 * WINDOW + 1);
	localparam int SUM_W      = PROD_W + FILL_W;
	localparam int TW_W       = WEIGHT_W + FILL_W;

	typedef struct packed {
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic        [WEIGHT_W-1:0] w;
	} ring_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_EVICT,
		ST_ADD,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	ring_entry_t ring_mem [WINDOW];
	ring_entry_t rd_q;
	ring_entry_t smp_q;
	ring_entry_t src;

	logic                      cmd_q;
	logic [IDX_W-1:0]          slot_q;
	logic [IDX_W-1:0]          oldest_q;
	logic [FILL_W-1:0]         fill_q;
	logic [STEP_W-1:0]         step_q;
	axis_t                     div_axis_q;

	logic signed [COORD_W-1:0] res_x_q;
	logic signed [COORD_W-1:0] res_y_q;
	logic signed [COORD_W-1:0] res_z_q;
	logic                      res_zero_q;

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] mean_x_q;
	logic signed [COORD_W-1:0] mean_y_q;
	logic signed [COORD_W-1:0] mean_z_q;
	logic        [HELD_W-1:0]  held_q;
	logic                      zero_q;

	acc_ctrl_t                 acc_ctrl;
	logic signed [COORD_W-1:0] operand;
	logic signed [SUM_W-1:0]   sum_x;
	logic signed [SUM_W-1:0]   sum_y;
	logic signed [SUM_W-1:0]   sum_z;
	logic        [TW_W-1:0]    total;

	logic                      div_start;
	logic signed [SUM_W-1:0]   dividend;
	logic                      div_done;
	logic signed [COORD_W-1:0] quotient;

	logic [SLOT_SUM_W-1:0]     slot_sum;
	logic [IDX_W-1:0]          append_slot;
	logic [IDX_W-1:0]          next_oldest;

	// Appending goes to oldest + fill, which stays below twice the window.
	assign slot_sum    = SLOT_SUM_W'(oldest_q) + SLOT_SUM_W'(fill_q);
	assign append_slot = (slot_sum >= SLOT_SUM_W'(WINDOW)) ?
	                     IDX_W'(slot_sum - SLOT_SUM_W'(WINDOW)) : IDX_W'(slot_sum);
	assign next_oldest = (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

	// Window storage; the read port always looks at the oldest entry.
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD && step_q == '0) begin
			ring_mem[slot_q] <= smp_q;
		end
		rd_q <= ring_mem[oldest_q];
	end

	// Each pass loads x, y, z and the weight in turn; each accumulate follows in the cycle after its load.
	assign src = (state_q == ST_EVICT) ? rd_q : smp_q;

	always_comb begin
		case (step_q[1:0])
			2'd0:    operand = src.x;
			2'd1:    operand = src.y;
			2'd2:    operand = src.z;
			default: operand = COORD_W'(signed'(2'sb01));
		endcase
	end

	always_comb begin
		acc_ctrl          = '0;
		acc_ctrl.clear    = (state_q == ST_PREP) && (cmd_q == CMD_START);
		acc_ctrl.axis     = axis_t'(step_q[1:0] - 2'd1);
		if (state_q == ST_EVICT || state_q == ST_ADD) begin
			acc_ctrl.load     = (step_q != STEP_LAST);
			acc_ctrl.accum    = (step_q != '0);
			acc_ctrl.subtract = (state_q == ST_EVICT);
		end
	end

	wwpm_acc #(
		.SUM_W (SUM_W),
		.TW_W  (TW_W)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.operand (operand),
		.factor  (src.w),
		.sum_x   (sum_x),
		.sum_y   (sum_y),
		.sum_z   (sum_z),
		.total   (total)
	);

	always_comb begin
		unique case (div_axis_q)
			AXIS_X:  dividend = sum_x;
			AXIS_Y:  dividend = sum_y;
			default: dividend = sum_z;
		endcase
	end

	assign div_start = (state_q == ST_DIV_START) && (total != '0);

	wwpm_div #(
		.DVD_W (SUM_W),
		.DVS_W (TW_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (total),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= 1'b0;
			smp_q       <= '0;
			slot_q      <= '0;
			oldest_q    <= '0;
			fill_q      <= '0;
			step_q      <= '0;
			div_axis_q  <= AXIS_X;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_z_q     <= '0;
			res_zero_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mean_x_q    <= '0;
			mean_y_q    <= '0;
			mean_z_q    <= '0;
			held_q      <= '0;
			zero_q      <= 1'b0;
		end else begin
			// The finish state reloads the output register itself.
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						smp_q   <= '{x: sample_x, y: sample_y, z: sample_z, w: weight};
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					step_q <= '0;
					if (cmd_q == CMD_START) begin
						slot_q   <= '0;
						oldest_q <= '0;
						fill_q   <= FILL_W'(1);
						state_q  <= ST_ADD;
					end else if (fill_q < FILL_W'(WINDOW)) begin
						slot_q  <= append_slot;
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_ADD;
					end else begin
						slot_q  <= oldest_q;
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (step_q == STEP_LAST) begin
						step_q   <= '0;
						oldest_q <= next_oldest;
						state_q  <= ST_ADD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ADD: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (cmd_q == CMD_START) begin
							res_x_q    <= smp_q.x;
							res_y_q    <= smp_q.y;
							res_z_q    <= smp_q.z;
							res_zero_q <= 1'b0;
							state_q    <= ST_FINISH;
						end else begin
							div_axis_q <= AXIS_X;
							state_q    <= ST_DIV_START;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV_START: begin
					if (total == '0) begin
						res_x_q    <= '0;
						res_y_q    <= '0;
						res_z_q    <= '0;
						res_zero_q <= 1'b1;
						state_q    <= ST_FINISH;
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						unique case (div_axis_q)
							AXIS_X: begin
								res_x_q    <= quotient;
								div_axis_q <= AXIS_Y;
								state_q    <= ST_DIV_START;
							end
							AXIS_Y: begin
								res_y_q    <= quotient;
								div_axis_q <= AXIS_Z;
								state_q    <= ST_DIV_START;
							end
							default: begin
								res_z_q    <= quotient;
								res_zero_q <= 1'b0;
								state_q    <= ST_FINISH;
							end
						endcase
					end
				end
				ST_FINISH: begin
					// Hold the result until the output register is free.
					if (!out_valid_q || out_ready) begin
						mean_x_q    <= res_x_q;
						mean_y_q    <= res_y_q;
						mean_z_q    <= res_z_q;
						held_q      <= HELD_W'(fill_q);
						zero_q      <= res_zero_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign mean_x      = mean_x_q;
	assign mean_y      = mean_y_q;
	assign mean_z      = mean_z_q;
	assign held_count  = held_q;
	assign zero_weight = zero_q;

endmodule
